>>> sv/isl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg
// Shared widths, codes and cell control type for the indexed shift list.
// ----------------------------------------------------------------------------
package isl_pkg;

    // Fixed field widths of the request and result beats
    localparam int CMD_BITS      = 2;
    localparam int POS_BITS      = 5;
    localparam int WORD_BITS     = 32;
    localparam int COUNT_BITS    = 5;
    localparam int STATUS_BITS   = 2;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_DATA_BITS = 32;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic                shift_up;
        logic                shift_down;
        logic [POS_BITS-1:0] position;
    } cell_ctrl_t;

endpackage

>>> sv/isl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_cell
// One storage slot of the list. Loads new data, its lower neighbour or its
// upper neighbour, and offers its entry when the position selects it.
// ----------------------------------------------------------------------------
module isl_cell #(
    parameter int CAPACITY  = 16,
    parameter int DATA_BITS = 32,
    parameter int INDEX     = 0
) (
    input  logic                   clk,
    input  isl_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_BITS-1:0]   new_data,
    input  logic [DATA_BITS-1:0]   lower_data,
    input  logic [DATA_BITS-1:0]   upper_data,
    output logic [DATA_BITS-1:0]   entry,
    output logic [DATA_BITS-1:0]   hit_data
);
    import isl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (IDX_W > POS_BITS) ? IDX_W : POS_BITS;

    logic [CMP_W-1:0]     my_index;
    logic [CMP_W-1:0]     pos_c;
    logic                 at_pos;
    logic                 above_pos;
    logic [DATA_BITS-1:0] entry_reg;
    logic [DATA_BITS-1:0] entry_next;

    assign my_index  = CMP_W'(INDEX);
    assign pos_c     = CMP_W'(ctrl.position);
    assign at_pos    = (my_index == pos_c);
    assign above_pos = (my_index > pos_c);

    // Pick the next entry: insert opens a gap, erase closes one
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_up)
        begin
            if (at_pos)
                entry_next = new_data;
            else if (above_pos)
                entry_next = lower_data;
        end
        else if (ctrl.shift_down)
        begin
            if (at_pos || above_pos)
                entry_next = upper_data;
        end
    end

    // Hold the entry; payload only, so no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Offer the entry to the read tree when selected
    assign entry    = entry_reg;
    assign hit_data = at_pos ? entry_reg : '0;

endmodule

>>> sv/indexed_shift_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_list
// Fixed-capacity ordered list with insert, erase and read at an index,
// built as a row of cells that shift together.
// ----------------------------------------------------------------------------
//  channel  | handshake            | fields
//  ---------+----------------------+--------------------------------------
//  request  | req_valid, req_stall | command, position, data_in
//  result   | rsp_valid, rsp_stall | data_out, element_count, status
//
// One request is taken per cycle unless req_stall holds it; its result beat
// appears in the next cycle from the output register. All cells shift in the
// same cycle, so the single output register is the only register on the path.
// Reset empties the list (count to zero); cell contents are left as they are.
// A stalled result holds the request side only while the output is occupied.
// ----------------------------------------------------------------------------
module indexed_shift_list #(
    parameter int CAPACITY  = isl_pkg::DEF_CAPACITY,
    parameter int DATA_BITS = isl_pkg::DEF_DATA_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [isl_pkg::CMD_BITS-1:0]      command,
    input  logic [isl_pkg::POS_BITS-1:0]      position,
    input  logic [isl_pkg::WORD_BITS-1:0]     data_in,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [isl_pkg::WORD_BITS-1:0]     data_out,
    output logic [isl_pkg::COUNT_BITS-1:0]    element_count,
    output logic [isl_pkg::STATUS_BITS-1:0]   status
);
    import isl_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
    localparam int WIDE_W  = DATA_BITS + WORD_BITS;
    localparam int CWIDE_W = CNT_W + COUNT_BITS;

    logic                   fire;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CMP_W-1:0]       count_c;
    logic [CMP_W-1:0]       pos_c;
    logic                   full;
    logic                   ins_ok;
    logic                   ers_ok;
    logic                   rd_ok;
    status_t                status_c;
    logic [WIDE_W-1:0]      din_wide;
    logic [DATA_BITS-1:0]   din_trim;
    logic [DATA_BITS-1:0]   read_or;
    logic [WIDE_W-1:0]      rd_wide;
    logic [CWIDE_W-1:0]     cnt_wide;
    cell_ctrl_t             ctrl;

    logic [DATA_BITS-1:0]   cell_entry [CAPACITY];
    logic [DATA_BITS-1:0]   cell_hit   [CAPACITY];

    logic                   rsp_valid_reg;
    logic [WORD_BITS-1:0]   data_out_reg;
    logic [COUNT_BITS-1:0]  count_out_reg;
    status_t                status_reg;

    // Take a request when the output register is free or draining
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign fire      = req_valid && !req_stall;

    // Bounds and capacity checks
    assign count_c = CMP_W'(count_reg);
    assign pos_c   = CMP_W'(position);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ins_ok   = 1'b0;
        ers_ok   = 1'b0;
        rd_ok    = 1'b0;
        status_c = ST_OK;
        unique case (command)
            CMD_INSERT:
            begin
                if (full)
                    status_c = ST_FULL;
                else if (pos_c > count_c)
                    status_c = ST_RANGE;
                else
                    ins_ok = 1'b1;
            end
            CMD_ERASE:
            begin
                if (pos_c >= count_c)
                    status_c = ST_RANGE;
                else
                    ers_ok = 1'b1;
            end
            CMD_READ:
            begin
                if (pos_c >= count_c)
                    status_c = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    // Advance the count
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (ers_ok)
            count_next = count_reg - CNT_W'(1);
    end

    // Broadcast control to the row
    assign ctrl.shift_up   = fire && ins_ok;
    assign ctrl.shift_down = fire && ers_ok;
    assign ctrl.position   = position;

    assign din_wide = WIDE_W'(data_in);
    assign din_trim = din_wide[DATA_BITS-1:0];

    // Row of cells, each wired to its neighbours
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_BITS-1:0] lower_d;
        logic [DATA_BITS-1:0] upper_d;

        if (i == 0)
        begin : g_first
            assign lower_d = din_trim;
        end
        else
        begin : g_mid_lo
            assign lower_d = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_d = cell_entry[i];
        end
        else
        begin : g_mid_hi
            assign upper_d = cell_entry[i+1];
        end

        isl_cell #(
            .CAPACITY  (CAPACITY),
            .DATA_BITS (DATA_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_data   (din_trim),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .entry      (cell_entry[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Merge the selected entry; at most one cell hits
    always_comb
    begin
        read_or = '0;
        for (int k = 0; k < CAPACITY; k++)
            read_or = read_or | cell_hit[k];
    end

    assign rd_wide  = rd_ok ? WIDE_W'(read_or) : '0;
    assign cnt_wide = CWIDE_W'(count_next);

    // Hold the count and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_out_reg  <= rd_wide[WORD_BITS-1:0];
            count_out_reg <= cnt_wide[COUNT_BITS-1:0];
            status_reg    <= status_c;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign data_out      = data_out_reg;
    assign element_count = count_out_reg;
    assign status        = status_reg;

endmodule

>>> dv/indexed_shift_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_list_tb
// Self-checking bench for the indexed shift list. Directed requests cover the
// empty list, the shift order on insert and erase, and the full list. Random
// insert, erase and read traffic follows, in phases with no idling, sender
// gaps, result stalls and both. Every result beat is checked against a local
// model of the list contents and element count.
// ----------------------------------------------------------------------------
module indexed_shift_list_tb;
    import isl_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;
    localparam int CLK_HALF = 6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [COUNT_BITS-1:0] count;
        status_t               code;
    } list_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    logic [CMD_BITS-1:0]    command;
    logic [POS_BITS-1:0]    position;
    logic [WORD_BITS-1:0]   data_in;
    logic                   rsp_valid;
    logic                   rsp_stall;
    logic [WORD_BITS-1:0]   data_out;
    logic [COUNT_BITS-1:0]  element_count;
    logic [STATUS_BITS-1:0] status;

    // Local copy of the list
    logic [WORD_BITS-1:0] list_entries [CAPACITY];
    int                   list_count = 0;
    list_result_t         pending_results [$];

    int idle_pct;
    int stall_pct;
    int error_count;

    indexed_shift_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .command       (command),
        .position      (position),
        .data_in       (data_in),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .data_out      (data_out),
        .element_count (element_count),
        .status        (status)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Apply one request to the local list and return the result it yields
    function automatic list_result_t predict_list_result(
        input logic [CMD_BITS-1:0]  cmd,
        input logic [POS_BITS-1:0]  pos,
        input logic [WORD_BITS-1:0] value
    );
        list_result_t res;
        res.word = '0;
        res.code = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                // full is checked ahead of the position
                if (list_count >= CAPACITY)
                    res.code = ST_FULL;
                else if (int'(pos) > list_count)
                    res.code = ST_RANGE;
                else
                begin
                    for (int j = list_count; j > int'(pos); j--)
                        list_entries[j] = list_entries[j - 1];
                    list_entries[pos] = value;
                    list_count++;
                end
            end
            CMD_ERASE:
            begin
                if (int'(pos) >= list_count)
                    res.code = ST_RANGE;
                else
                begin
                    for (int j = int'(pos) + 1; j < list_count; j++)
                        list_entries[j - 1] = list_entries[j];
                    list_count--;
                end
            end
            CMD_READ:
            begin
                if (int'(pos) >= list_count)
                    res.code = ST_RANGE;
                else
                    res.word = list_entries[pos];
            end
            default:
            begin
                // unused command: no change, ok, zero data
            end
        endcase
        res.count = list_count[COUNT_BITS-1:0];
        return res;
    endfunction

    // Drive one request beat, with random gaps ahead of it, and wait for it
    // to be taken
    task automatic send_request(
        input logic [CMD_BITS-1:0]  cmd,
        input logic [POS_BITS-1:0]  pos,
        input logic [WORD_BITS-1:0] value
    );
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        position  <= pos;
        data_in   <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(predict_list_result(cmd, pos, value));
    endtask

    task automatic check_field(
        input string       field,
        input logic [31:0] exp_val,
        input logic [31:0] act_val
    );
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h",
                     $time, field, exp_val, act_val);
            error_count++;
        end
    endtask

    // Check each result beat against the oldest prediction; stall at random
    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual %h %0d %0d",
                         $time, data_out, element_count, status);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("data_out", exp_res.word, data_out);
                check_field("element_count", 32'(exp_res.count), 32'(element_count));
                check_field("status", 32'(exp_res.code), 32'(status));
            end
        end
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Requests on an empty list, including the unused command
    task automatic test_empty_list();
        idle_pct  = 0;
        stall_pct = 0;
        send_request(CMD_READ, 5'd0, 32'h0000_0000);
        send_request(CMD_ERASE, 5'd0, ALL_ONES);
        send_request(CMD_INSERT, 5'd1, 32'h1234_5678);
        send_request(CMD_UNUSED, 5'd31, ALL_ONES);
    endtask

    // Insert at front, middle and end, then erase and read back the order
    task automatic test_shift_order();
        send_request(CMD_INSERT, 5'd0, 32'h0000_0000);
        send_request(CMD_INSERT, 5'd1, ALL_ONES);
        send_request(CMD_INSERT, 5'd0, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, 5'd1, 32'h5A5A_5A5A);
        send_request(CMD_READ, 5'd0, 32'h0000_0000);
        send_request(CMD_READ, 5'd3, 32'h0000_0000);
        send_request(CMD_INSERT, 5'd5, 32'hDEAD_BEEF);
        send_request(CMD_ERASE, 5'd1, 32'h0000_0000);
        send_request(CMD_ERASE, 5'd2, 32'h0000_0000);
        send_request(CMD_READ, 5'd1, 32'h0000_0000);
        send_request(CMD_READ, 5'd31, 32'h0000_0000);
        send_request(CMD_ERASE, 5'd3, 32'h0000_0000);
    endtask

    // Fill the list, then refuse inserts and probe the top entry
    task automatic test_full_list();
        while (list_count < CAPACITY)
            send_request(CMD_INSERT, POS_BITS'(list_count), $urandom);
        send_request(CMD_INSERT, 5'd31, 32'hCAFE_F00D);
        send_request(CMD_INSERT, 5'd0, 32'hCAFE_F00D);
        send_request(CMD_READ, 5'd15, 32'h0000_0000);
        send_request(CMD_ERASE, 5'd16, 32'h0000_0000);
        send_request(CMD_ERASE, 5'd0, 32'h0000_0000);
        send_request(CMD_READ, 5'd14, 32'h0000_0000);
    endtask

    // Random traffic that swings between filling and draining the list
    task automatic test_random_traffic(input int gap_pct, input int hold_pct, input int items);
        logic [CMD_BITS-1:0]  cmd;
        logic [POS_BITS-1:0]  pos;
        logic [WORD_BITS-1:0] value;
        int                   pick;
        int                   insert_weight;
        idle_pct  = gap_pct;
        stall_pct = hold_pct;
        for (int n = 0; n < items; n++)
        begin
            insert_weight = ((n / 40) % 2 == 0) ? 70 : 10;
            pick = $urandom_range(99);
            if (pick < insert_weight)
                cmd = CMD_INSERT;
            else if (pick < 96)
                cmd = $urandom_range(1) ? CMD_ERASE : CMD_READ;
            else
                cmd = CMD_UNUSED;

            // mostly in range, now and then any position
            if ($urandom_range(9) == 0 || cmd == CMD_UNUSED)
                pos = POS_BITS'($urandom);
            else if (cmd == CMD_INSERT)
                pos = POS_BITS'($urandom_range(list_count));
            else
                pos = (list_count > 0) ? POS_BITS'($urandom_range(list_count - 1)) : '0;

            case ($urandom_range(9))
                0:       value = '0;
                1:       value = ALL_ONES;
                default: value = $urandom;
            endcase
            send_request(cmd, pos, value);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        command     <= CMD_INSERT;
        position    <= '0;
        data_in     <= '0;
        rsp_stall   <= 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        error_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_shift_order();
        test_full_list();
        test_random_traffic(0, 0, 100);
        test_random_traffic(55, 0, 100);
        test_random_traffic(0, 55, 100);
        test_random_traffic(35, 35, 100);

        // drop valid and let the remaining results drain
        req_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        for (int k = 0; k < 1000 && pending_results.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: missing results: expected 0 outstanding, actual %0d",
                     $time, pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("indexed_shift_list test passed");
        else
            $display("indexed_shift_list test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("indexed_shift_list test failed");
        $finish;
    end

endmodule
